// ----- src/wdsc_pkg.sv -----
// ----------------------------------------------------------------------------
// wdsc_pkg: shared types and constants
// Access word, result word and fixed widths of the distinct-stripe counter.
// ----------------------------------------------------------------------------
package wdsc_pkg;

    localparam int unsigned MODE_W   = 1;
    localparam int unsigned OFFSET_W = 48;
    localparam int unsigned SIZE_W   = 32;
    localparam int unsigned WLEN_W   = 21;
    localparam int unsigned DIST_W   = 14;
    localparam int unsigned WIN_W    = 16;
    localparam int unsigned SUM_W    = 32;

    // last byte address can exceed the offset range by the size range
    localparam int unsigned END_W    = OFFSET_W + 1;

    // 1 MiB chunks, six chunks per stripe: the address is shifted right by
    // the chunk size plus one (the factor two of six), then divided by three
    localparam int unsigned CHUNK_SH  = 20;
    localparam int unsigned STRIPE_SH = CHUNK_SH + 1;
    localparam int unsigned QIN_W     = END_W - STRIPE_SH;
    localparam logic [31:0] RECIP_3   = 32'hAAAA_AAAB;
    localparam int unsigned RECIP_SH  = 33;
    localparam int unsigned PROD_W    = QIN_W + 32;
    // highest stripe index of any access fits in 26 bits
    localparam int unsigned STRIPE_W  = 26;

    localparam int unsigned BUCKETS  = 128;
    localparam int unsigned BKT_W    = 7;

    localparam logic [1:0]        ADDR_WLEN  = 2'd0;
    localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(1024);
    localparam logic [MODE_W-1:0] MODE_WRITE = 1'b0;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [OFFSET_W-1:0] offset;
        logic [SIZE_W-1:0]   size;
        logic                last_of_trace;
    } t_in_item;

    typedef struct packed {
        logic [DIST_W-1:0] distinct_count;
        logic [WIN_W-1:0]  windows_closed;
        logic [SUM_W-1:0]  locality_sum;
        logic              bucket_full;
        logic              trace_done;
    } t_out_item;

endpackage

// ----- src/windowed_distinct_stripe_counter.sv -----
// ----------------------------------------------------------------------------
// windowed_distinct_stripe_counter: per-window distinct stripe count
// Sequencer around a shared stripe index unit, a stripe table RAM and a
// fill RAM.
// ----------------------------------------------------------------------------
// One access word is taken when start is high and busy is low; busy drops in
// the cycle its result word is shown on o_result under o_result_valid (unless
// the word ends a trace), so the next word can be taken at the edge that ends
// that cycle. The receiver cannot stall. A read goes from idle straight to
// returning its result. A write runs the stripe index unit twice (first and
// last stripe), then per covered stripe reads the fill count of the stripe's
// bucket and scans that bucket's slots in the stripe table one slot at a
// time until a hit or the end of the fill, then returns the result. A write
// that closes a window adds a clearing pass over all BUCKETS entries of the
// fill RAM ahead of its stripe work; the end of a trace runs the same pass
// right after its result word, and after reset the pass runs before the
// first word is taken (configuration writes are taken throughout).
// ----------------------------------------------------------------------------
module windowed_distinct_stripe_counter
    import wdsc_pkg::*;
#(
    parameter int unsigned ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  t_in_item    i_item,
    output logic        busy,
    output logic        o_result_valid,
    output t_out_item   o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned FILL_W       = $clog2(ENTRIES + 1);
    localparam int unsigned TAB_DEPTH    = BUCKETS * ENTRIES;
    localparam int unsigned TAB_AW       = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;
    localparam logic [WIN_W-1:0]  WIN_MAX  = '1;

    typedef enum logic [9:0] {
        S_CLEAR     = 10'b0000000001,
        S_IDLE      = 10'b0000000010,
        S_DIV_GO    = 10'b0000000100,
        S_DIV_WAIT  = 10'b0000001000,
        S_FILL_RD   = 10'b0000010000,
        S_FILL_WAIT = 10'b0000100000,
        S_SCAN_RD   = 10'b0001000000,
        S_SCAN_CMP  = 10'b0010000000,
        S_NEXT      = 10'b0100000000,
        S_FINISH    = 10'b1000000000
    } t_state;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'b01,
        PH_FINAL  = 2'b10
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;

    logic [WLEN_W-1:0]   r_wlen;
    logic [WLEN_W-1:0]   r_wcnt, n_wcnt;
    logic [DIST_W-1:0]   r_dist, n_dist;
    logic [WIN_W-1:0]    r_win, n_win;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic                r_go, n_go;
    logic                r_full, n_full;
    logic                r_last, n_last;
    logic [BKT_W-1:0]    r_clr, n_clr;
    logic [OFFSET_W-1:0] r_offset, n_offset;
    logic [END_W-1:0]    r_end, n_end;
    logic [STRIPE_W-1:0] r_first, n_first;
    logic [STRIPE_W-1:0] r_final, n_final;
    logic [STRIPE_W-1:0] r_stripe, n_stripe;
    logic [BKT_W-1:0]    r_bucket, n_bucket;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [FILL_W-1:0]   r_slot, n_slot;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    logic                cfg_wr;
    logic                accept;
    logic [WLEN_W-1:0]   wcnt_inc;
    logic [SUM_W:0]      sum_add;
    logic [SUM_W-1:0]    sum_closed;
    logic [WIN_W-1:0]    win_closed;
    logic [SIZE_W-1:0]   size_m1;

    logic                div_start, div_done;
    logic [END_W-1:0]    div_addr;
    logic [STRIPE_W-1:0] div_stripe;

    logic [TAB_AW-1:0]   tab_base;
    logic                tab_we;
    logic [TAB_AW-1:0]   tab_waddr, tab_raddr;
    logic [STRIPE_W-1:0] tab_rdata;
    logic                fill_we;
    logic [BKT_W-1:0]    fill_waddr;
    logic [FILL_W-1:0]   fill_wdata, fill_rdata;
    logic [FILL_W-1:0]   cur_fill;
    logic                do_insert;
    logic [FILL_W:0]     slot_inc;

    // ---- configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = 32'(r_wlen);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen <= WLEN_RESET;
        end else if (cfg_wr && paddr == ADDR_WLEN) begin
            r_wlen <= pwdata[WLEN_W-1:0];
        end
    end

    // ---- shared stripe index unit
    always_comb begin
        div_addr = END_W'(r_offset);
        case (r_phase)
            PH_FIRST: div_addr = END_W'(r_offset);
            PH_FINAL: div_addr = r_end;
            default:  div_addr = END_W'(r_offset);
        endcase
    end

    assign div_start = (r_state == S_DIV_GO);

    wdsc_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_addr   (div_addr),
        .o_done   (div_done),
        .o_stripe (div_stripe)
    );

    // ---- stripe table and fill counts
    assign tab_base  = TAB_AW'(r_bucket) * TAB_AW'(ENTRIES);
    assign cur_fill  = (r_state == S_FILL_WAIT) ? fill_rdata : r_fill;
    assign tab_raddr = tab_base + TAB_AW'(r_slot);
    assign tab_waddr = tab_base + TAB_AW'(cur_fill);
    assign slot_inc  = {1'b0, r_slot} + 1'b1;

    always_comb begin
        do_insert = 1'b0;
        case (r_state)
            S_FILL_WAIT: do_insert = (fill_rdata == '0);
            S_SCAN_CMP:  do_insert = (tab_rdata != r_stripe) &&
                                     (slot_inc >= {1'b0, r_fill});
            default:     do_insert = 1'b0;
        endcase
    end

    assign tab_we     = do_insert && ({1'b0, cur_fill} < (FILL_W + 1)'(ENTRIES));
    assign fill_we    = (r_state == S_CLEAR) || tab_we;
    assign fill_waddr = (r_state == S_CLEAR) ? r_clr : r_bucket;
    assign fill_wdata = (r_state == S_CLEAR) ? '0 : FILL_W'(cur_fill + 1'b1);

    wdsc_ram #(
        .WIDTH (STRIPE_W),
        .DEPTH (TAB_DEPTH)
    ) u_tab (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (r_stripe),
        .i_raddr (tab_raddr),
        .o_rdata (tab_rdata)
    );

    wdsc_ram #(
        .WIDTH (FILL_W),
        .DEPTH (BUCKETS)
    ) u_fill (
        .i_clk   (i_clk),
        .i_we    (fill_we),
        .i_waddr (fill_waddr),
        .i_wdata (fill_wdata),
        .i_raddr (r_bucket),
        .o_rdata (fill_rdata)
    );

    // ---- sequencer
    assign accept     = start && (r_state == S_IDLE);
    assign wcnt_inc   = r_wcnt + 1'b1;
    assign sum_add    = {1'b0, r_sum} + (SUM_W + 1)'(r_dist);
    assign sum_closed = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    assign win_closed = (r_win == WIN_MAX) ? r_win : r_win + 1'b1;
    assign size_m1    = (i_item.size == '0) ? '0 : i_item.size - 1'b1;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_wcnt      = r_wcnt;
        n_dist      = r_dist;
        n_win       = r_win;
        n_sum       = r_sum;
        n_go        = r_go;
        n_full      = r_full;
        n_last      = r_last;
        n_clr       = r_clr;
        n_offset    = r_offset;
        n_end       = r_end;
        n_first     = r_first;
        n_final     = r_final;
        n_stripe    = r_stripe;
        n_bucket    = r_bucket;
        n_fill      = r_fill;
        n_slot      = r_slot;
        n_out_valid = 1'b0;
        n_out       = r_out;

        if (do_insert) begin
            if (tab_we) begin
                if (r_dist != DIST_MAX) begin
                    n_dist = r_dist + 1'b1;
                end
            end else begin
                n_full = 1'b1;
            end
        end

        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == BKT_W'(BUCKETS - 1)) begin
                    n_clr   = '0;
                    n_phase = PH_FIRST;
                    n_state = r_go ? S_DIV_GO : S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_full   = 1'b0;
                    n_last   = i_item.last_of_trace;
                    n_offset = i_item.offset;
                    n_end    = END_W'(i_item.offset) + END_W'(size_m1);
                    n_phase  = PH_FIRST;
                    n_go     = 1'b0;
                    if (i_item.mode == MODE_WRITE) begin
                        n_wcnt = wcnt_inc;
                        if (wcnt_inc == r_wlen) begin
                            // window closes ahead of this write
                            n_sum   = sum_closed;
                            n_win   = win_closed;
                            n_dist  = '0;
                            n_wcnt  = '0;
                            n_go    = 1'b1;
                            n_clr   = '0;
                            n_state = S_CLEAR;
                        end else begin
                            n_state = S_DIV_GO;
                        end
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_DIV_GO: begin
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    case (r_phase)
                        PH_FIRST: begin
                            n_first = div_stripe;
                            n_phase = PH_FINAL;
                            n_state = S_DIV_GO;
                        end
                        PH_FINAL: begin
                            n_final  = div_stripe;
                            n_stripe = r_first;
                            n_bucket = r_first[BKT_W-1:0];
                            n_state  = S_FILL_RD;
                        end
                        default: begin
                            n_phase = PH_FIRST;
                            n_state = S_DIV_GO;
                        end
                    endcase
                end
            end
            S_FILL_RD: begin
                n_state = S_FILL_WAIT;
            end
            S_FILL_WAIT: begin
                n_fill  = fill_rdata;
                n_slot  = '0;
                n_state = do_insert ? S_NEXT : S_SCAN_RD;
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (tab_rdata == r_stripe || do_insert) begin
                    n_state = S_NEXT;
                end else begin
                    n_slot  = slot_inc[FILL_W-1:0];
                    n_state = S_SCAN_RD;
                end
            end
            S_NEXT: begin
                if (r_stripe == r_final) begin
                    n_state = S_FINISH;
                end else begin
                    n_stripe = r_stripe + 1'b1;
                    // bucket count is a power of two, so the bucket wraps with the stripe
                    n_bucket = r_bucket + 1'b1;
                    n_state  = S_FILL_RD;
                end
            end
            S_FINISH: begin
                n_out_valid          = 1'b1;
                n_out.distinct_count = r_dist;
                n_out.bucket_full    = r_full;
                n_out.trace_done     = r_last;
                n_out.windows_closed = r_last ? win_closed : r_win;
                n_out.locality_sum   = r_last ? sum_closed : r_sum;
                n_state              = S_IDLE;
                if (r_last) begin
                    n_dist  = '0;
                    n_wcnt  = '0;
                    n_win   = '0;
                    n_sum   = '0;
                    n_go    = 1'b0;
                    n_clr   = '0;
                    n_state = S_CLEAR;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_clr   = '0;
                n_go    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_phase     <= PH_FIRST;
            r_wcnt      <= '0;
            r_dist      <= '0;
            r_win       <= '0;
            r_sum       <= '0;
            r_go        <= 1'b0;
            r_full      <= 1'b0;
            r_last      <= 1'b0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_wcnt      <= n_wcnt;
            r_dist      <= n_dist;
            r_win       <= n_win;
            r_sum       <= n_sum;
            r_go        <= n_go;
            r_full      <= n_full;
            r_last      <= n_last;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
        r_offset <= n_offset;
        r_end    <= n_end;
        r_first  <= n_first;
        r_final  <= n_final;
        r_stripe <= n_stripe;
        r_bucket <= n_bucket;
        r_fill   <= n_fill;
        r_slot   <= n_slot;
        r_out    <= n_out;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

// ----- src/wdsc_ram.sv -----
// ----------------------------------------------------------------------------
// wdsc_ram: generic RAM
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
module wdsc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/wdsc_div.sv -----
// ----------------------------------------------------------------------------
// wdsc_div: stripe index unit
// Byte address to stripe index by shift and reciprocal multiply; done pulses
// in the cycle after start, with the index valid.
// ----------------------------------------------------------------------------
module wdsc_div
    import wdsc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [END_W-1:0]    i_addr,
    output logic                o_done,
    output logic [STRIPE_W-1:0] o_stripe
);

    logic                r_done;
    logic [STRIPE_W-1:0] r_stripe, n_stripe;
    logic [QIN_W-1:0]    half_chunk;
    logic [PROD_W-1:0]   prod;

    assign half_chunk = i_addr[END_W-1:STRIPE_SH];
    // exact divide by three for any operand below 2^32
    assign prod       = PROD_W'(half_chunk) * PROD_W'(RECIP_3);
    assign n_stripe   = i_start ? prod[RECIP_SH +: STRIPE_W] : r_stripe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
        r_stripe <= n_stripe;
    end

    assign o_done   = r_done;
    assign o_stripe = r_stripe;

endmodule

// ----- bench/windowed_distinct_stripe_counter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_distinct_stripe_counter_tb: self-checking bench
// Feeds access words through the start/busy port, predicts every result word
// with a bucketed stripe set kept in the bench, and checks each result field
// by field. The window length is rewritten between phases over APB.
// ----------------------------------------------------------------------------
module windowed_distinct_stripe_counter_tb
    import wdsc_pkg::*;
;

    localparam int unsigned NBUCKETS = 128;
    localparam int unsigned NSLOTS   = 64;
    localparam longint unsigned CHUNK  = 1048576;
    localparam longint unsigned NCHUNK = 6;
    localparam int unsigned WATCHDOG_LIMIT = 500000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    t_in_item    i_item = '0;
    logic        busy;
    logic        o_result_valid;
    t_out_item   o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    windowed_distinct_stripe_counter dut (.*);

    always #5 i_clk = ~i_clk;

    // bench copy of the block state
    longint unsigned  stripe_sets[NBUCKETS][$];
    logic [WLEN_W-1:0] wlen_cfg = WLEN_RESET;
    logic [WLEN_W-1:0] wr_count = '0;
    logic [DIST_W-1:0] distinct_now = '0;
    logic [WIN_W-1:0]  win_count = '0;
    logic [SUM_W-1:0]  stripe_sum = '0;

    t_in_item  access_q[$];
    t_out_item result_q[$];
    int        idle_pct = 0;
    int        errors = 0;
    int        quiet_cycles = 0;
    t_in_item  cur_access;

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    endtask

    function automatic void clear_sets();
        foreach (stripe_sets[b]) stripe_sets[b].delete();
        distinct_now = '0;
    endfunction

    function automatic void close_window();
        longint unsigned s;
        s = longint'(stripe_sum) + distinct_now;
        stripe_sum = (s > 64'hFFFF_FFFF) ? '1 : s[SUM_W-1:0];
        if (win_count != '1) win_count++;
    endfunction

    function automatic t_out_item predict_counts(input t_in_item a);
        t_out_item r;
        longint unsigned first_s, last_s, len, b;
        bit full, hit;
        full = 0;
        r = '0;
        if (a.mode == MODE_WRITE) begin
            wr_count = wr_count + 1'b1;
            if (wr_count == wlen_cfg) begin
                close_window();
                clear_sets();
                wr_count = '0;
            end
            len = (a.size == 0) ? 1 : a.size;
            first_s = (longint'(a.offset) / CHUNK) / NCHUNK;
            last_s = ((longint'(a.offset) + len - 1) / CHUNK) / NCHUNK;
            for (longint unsigned s = first_s; s <= last_s; s++) begin
                b = s % NBUCKETS;
                hit = 0;
                for (int i = 0; i < stripe_sets[b].size(); i++)
                    if (stripe_sets[b][i] == s) hit = 1;
                if (!hit) begin
                    if (stripe_sets[b].size() >= NSLOTS) full = 1;
                    else begin
                        stripe_sets[b].push_back(s);
                        if (distinct_now != '1) distinct_now++;
                    end
                end
            end
        end
        r.distinct_count = distinct_now;
        if (a.last_of_trace) close_window();
        r.windows_closed = win_count;
        r.locality_sum = stripe_sum;
        r.bucket_full = full;
        r.trace_done = a.last_of_trace;
        if (a.last_of_trace) begin
            clear_sets();
            wr_count = '0;
            win_count = '0;
            stripe_sum = '0;
        end
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) result_q.push_back(predict_counts(cur_access));
            if (!start || !busy) begin
                if (access_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    cur_access = access_q.pop_front();
                    i_item <= cur_access;
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid) begin
                if (result_q.size() == 0) begin
                    report("unexpected word", 0, 0);
                end else begin
                    t_out_item w;
                    w = result_q.pop_front();
                    if (o_result.distinct_count !== w.distinct_count)
                        report("distinct_count", o_result.distinct_count, w.distinct_count);
                    if (o_result.windows_closed !== w.windows_closed)
                        report("windows_closed", o_result.windows_closed, w.windows_closed);
                    if (o_result.locality_sum !== w.locality_sum)
                        report("locality_sum", o_result.locality_sum, w.locality_sum);
                    if (o_result.bucket_full !== w.bucket_full)
                        report("bucket_full", o_result.bucket_full, w.bucket_full);
                    if (o_result.trace_done !== w.trace_done)
                        report("trace_done", o_result.trace_done, w.trace_done);
                end
            end
            if (o_result_valid || (start && !busy)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("windowed_distinct_stripe_counter_tb NOT OK");
                $finish;
            end
        end
    end

    task automatic write_wlen(input logic [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_WLEN; pwdata <= v; penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        wlen_cfg = v[WLEN_W-1:0];
    endtask

    task automatic drain();
        while (access_q.size() != 0 || start || result_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic t_in_item make_access(input bit rd, input longint unsigned off,
                                             input longint unsigned len, input bit last);
        t_in_item a;
        a.mode = rd;
        a.offset = off[OFFSET_W-1:0];
        a.size = len[SIZE_W-1:0];
        a.last_of_trace = last;
        return a;
    endfunction

    function automatic t_in_item random_access();
        longint unsigned off, len;
        int pick;
        pick = $urandom_range(99);
        if (pick < 8) off = {$urandom, $urandom};
        else off = longint'($urandom_range(1500)) * CHUNK * NCHUNK + $urandom_range(12582911);
        pick = $urandom_range(199);
        if (pick == 0) len = $urandom;
        else if (pick < 10) len = 0;
        else if (pick < 60) len = $urandom_range(40000000);
        else len = $urandom_range(1, 65536);
        return make_access($urandom_range(99) < 15, off, len, $urandom_range(99) < 4);
    endfunction

    initial begin
        int wl_list[6];
        int phase_idle[3];
        wl_list = '{1, 3, 0, 1048576, 17, 2097151};
        phase_idle = '{0, 46, 15};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, zero size, end of trace, reset window length
        access_q.push_back(make_access(1, 0, 0, 0));
        access_q.push_back(make_access(0, 0, 0, 0));
        access_q.push_back(make_access(0, 64'hFFFF_FFFF_FFFF, 1, 0));
        access_q.push_back(make_access(0, 64'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF, 0));
        access_q.push_back(make_access(0, 6291455, 2, 0));
        access_q.push_back(make_access(1, 64'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF, 1));
        access_q.push_back(make_access(0, 12582912, 1, 1));
        // full bucket: 66 distinct stripes mapping to bucket 5
        for (int k = 0; k < 66; k++)
            access_q.push_back(make_access(0, (5 + 128 * k) * CHUNK * NCHUNK, 1, 0));
        access_q.push_back(make_access(0, 5 * CHUNK * NCHUNK, 1, 1));
        drain();

        for (int p = 0; p < 6; p++) begin
            write_wlen(wl_list[p]);
            for (int n = 0; n < 54; n++) begin
                idle_pct = phase_idle[(n / 18) % 3];
                access_q.push_back(random_access());
                if (n % 18 == 17)
                    while (access_q.size() != 0) @(posedge i_clk);
            end
            drain();
        end
        write_wlen(32'(WLEN_RESET));
        drain();

        if (errors == 0) $display("windowed_distinct_stripe_counter_tb OK");
        else $display("windowed_distinct_stripe_counter_tb NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/wdsc_pkg.sv
src/wdsc_ram.sv
src/wdsc_div.sv
src/windowed_distinct_stripe_counter.sv
bench/windowed_distinct_stripe_counter_tb.sv
